[rtl/sme_pkg.sv]
package sme_pkg;

  localparam int MaxParticipants = 8;
  localparam int IdxW            = $clog2(MaxParticipants);
  localparam int CntW            = IdxW + 1;
  localparam int AddrW           = 2 * IdxW;
  localparam int CfgAddrW        = 3;
  localparam int CfgDataW        = 32;
  localparam int ActiveW         = 4;

  localparam logic [1:0] FuncLoadProp = 2'd0;
  localparam logic [1:0] FuncLoadAcc  = 2'd1;
  localparam logic [1:0] FuncRun      = 2'd2;

  localparam logic [CfgAddrW-1:0] AddrActiveCount = 3'd0;
  localparam logic [ActiveW-1:0]  ActiveReset     = 4'd8;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StSelect,
    StDecide,
    StScan,
    StEmit
  } state_e;

  typedef struct packed {
    logic load_prop;
    logic load_acc;
    logic init;
    logic pop;
    logic rd_prop;
    logic take;
    logic scan_start;
    logic scan_next;
    logic trade_up;
    logic emit_start;
    logic emit_adv;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic q_empty;
    logic slot_done;
    logic a_oor;
    logic a_taken;
    logic hit_chal;
    logic hit_inc;
    logic scan_end;
    logic emit_done;
    logic emit_taken;
    logic out_free;
  } status_t;

  // 0 acts as 1, anything above the table size acts as the table size
  function automatic logic [CntW-1:0] clamp_count(logic [ActiveW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) begin
      r = CntW'(1);
    end else if (32'(v) > MaxParticipants) begin
      r = CntW'(MaxParticipants);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

endpackage

[rtl/sme_ctrl.sv]
module sme_ctrl import sme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  input  status_t    status_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && func_i == FuncRun) state_d = StInit;
      end
      StInit: state_d = StSelect;
      StSelect: begin
        if (status_i.q_empty) begin
          state_d = StEmit;
        end else if (!status_i.slot_done) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (!status_i.a_oor && status_i.a_taken) begin
          state_d = StScan;
        end else begin
          state_d = StSelect;
        end
      end
      StScan: begin
        if (status_i.hit_chal || status_i.hit_inc || status_i.scan_end) state_d = StSelect;
      end
      StEmit: begin
        if (status_i.emit_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        cmd_o.load_prop = in_valid_i && (func_i == FuncLoadProp);
        cmd_o.load_acc  = in_valid_i && (func_i == FuncLoadAcc);
      end
      StInit: cmd_o.init = 1'b1;
      StSelect: begin
        if (status_i.q_empty) begin
          cmd_o.emit_start = 1'b1;
        end else if (status_i.slot_done) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.rd_prop = 1'b1;
        end
      end
      StDecide: begin
        if (!status_i.a_oor) begin
          if (!status_i.a_taken) begin
            cmd_o.take = 1'b1;
            cmd_o.pop  = 1'b1;
          end else begin
            cmd_o.scan_start = 1'b1;
          end
        end
      end
      StScan: begin
        if (status_i.hit_chal) begin
          cmd_o.trade_up = 1'b1;
          cmd_o.pop      = 1'b1;
        end else if (!status_i.hit_inc && !status_i.scan_end) begin
          cmd_o.scan_next = 1'b1;
        end
      end
      StEmit: begin
        if (!status_i.emit_done) begin
          if (!status_i.emit_taken) begin
            cmd_o.emit_adv = 1'b1;
          end else if (status_i.out_free) begin
            cmd_o.emit_load = 1'b1;
            cmd_o.emit_adv  = 1'b1;
          end
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/sme_datapath.sv]
module sme_datapath import sme_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [CntW-1:0] n_i,
  input  logic [2:0]      person_i,
  input  logic [2:0]      rank_slot_i,
  input  logic [2:0]      choice_i,
  input  logic            out_stall_i,
  output status_t         status_o,
  output logic            out_valid_o,
  output logic [2:0]      acceptor_id_o,
  output logic [2:0]      proposer_id_o,
  output logic            last_pair_o
);

  logic [IdxW-1:0] prop_mem [MaxParticipants*MaxParticipants];
  logic [IdxW-1:0] acc_mem  [MaxParticipants*MaxParticipants];
  logic [IdxW-1:0] prop_rd_q, acc_rd_q;

  logic [IdxW-1:0] queue_q   [MaxParticipants];
  logic [IdxW-1:0] partner_q [MaxParticipants];
  logic [CntW-1:0] next_slot_q [MaxParticipants];
  logic [MaxParticipants-1:0] taken_q;
  logic [IdxW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] a_q, scan_idx_q;
  logic [CntW-1:0] emit_idx_q;

  logic            out_valid_q, last_q;
  logic [IdxW-1:0] out_acc_q, out_prop_q;

  logic [IdxW-1:0]  m, incumbent;
  logic [CntW-1:0]  slot_m;
  logic [AddrW-1:0] prop_addr, acc_addr;
  logic             more;

  assign m         = queue_q[head_q];
  assign slot_m    = next_slot_q[m];
  assign incumbent = partner_q[a_q];
  assign prop_addr = {m, slot_m[IdxW-1:0]};
  assign acc_addr  = cmd_i.scan_start ? {prop_rd_q, {IdxW{1'b0}}}
                                      : {a_q, IdxW'(scan_idx_q + 1'b1)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prop) prop_mem[{person_i, rank_slot_i}] <= choice_i;
    if (cmd_i.rd_prop) prop_rd_q <= prop_mem[prop_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_acc) acc_mem[{person_i, rank_slot_i}] <= choice_i;
    if (cmd_i.scan_start || cmd_i.scan_next) acc_rd_q <= acc_mem[acc_addr];
  end

  // more pairs still to come after the current emit index
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < MaxParticipants; i++) begin
      if (CntW'(i) > emit_idx_q && CntW'(i) < n_i && taken_q[i]) more = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.pop && !cmd_i.trade_up) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      for (int i = 0; i < MaxParticipants; i++) queue_q[i] <= IdxW'(i);
    end else if (cmd_i.trade_up) begin
      queue_q[tail_q] <= incumbent;
    end
    if (cmd_i.take) partner_q[prop_rd_q] <= m;
    if (cmd_i.trade_up) partner_q[a_q] <= m;
    if (cmd_i.emit_load) begin
      out_acc_q  <= emit_idx_q[IdxW-1:0];
      out_prop_q <= partner_q[emit_idx_q[IdxW-1:0]];
      last_q     <= !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      taken_q     <= '0;
      a_q         <= '0;
      scan_idx_q  <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxParticipants; i++) next_slot_q[i] <= '0;
    end else begin
      if (cmd_i.init) begin
        head_q  <= '0;
        tail_q  <= n_i[IdxW-1:0];
        count_q <= n_i;
        taken_q <= '0;
        for (int i = 0; i < MaxParticipants; i++) next_slot_q[i] <= '0;
      end else begin
        if (cmd_i.pop) head_q <= head_q + 1'b1;
        if (cmd_i.trade_up) tail_q <= tail_q + 1'b1;
        count_q <= count_d;
        if (cmd_i.take) taken_q[prop_rd_q] <= 1'b1;
        if (cmd_i.rd_prop) next_slot_q[m] <= slot_m + 1'b1;
      end
      if (cmd_i.scan_start) begin
        a_q        <= prop_rd_q;
        scan_idx_q <= '0;
      end else if (cmd_i.scan_next) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.emit_start) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_adv) begin
        emit_idx_q <= emit_idx_q + 1'b1;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.q_empty    = (count_q == '0);
  assign status_o.slot_done  = (slot_m >= n_i);
  assign status_o.a_oor      = ({1'b0, prop_rd_q} >= n_i);
  assign status_o.a_taken    = taken_q[prop_rd_q];
  assign status_o.hit_chal   = (acc_rd_q == m);
  assign status_o.hit_inc    = (acc_rd_q == incumbent);
  assign status_o.scan_end   = (({1'b0, scan_idx_q} + 1'b1) >= n_i);
  assign status_o.emit_done  = (emit_idx_q >= n_i);
  assign status_o.emit_taken = taken_q[emit_idx_q[IdxW-1:0]];
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign acceptor_id_o = out_acc_q;
  assign proposer_id_o = out_prop_q;
  assign last_pair_o   = last_q;

endmodule

[rtl/stable_matching_engine.sv]
// Proposer-side deferred acceptance over two preference tables held in
// single-port RAMs. A load request writes one list entry. A run request
// first sets up the free queue, then for each proposal picks the head of the
// free queue and reads his next choice; when the acceptor is already matched,
// her list is scanned entry by entry until either man is found, so the
// proposal loop bounded by n*n proposals and the acceptor-table scan sets the
// run length. The acceptors are then walked to hand out the pairs, which takes
// longer if the output is stalled. The block takes no new request while a run
// is in progress. Results sit in an output register, so a run may start while
// its last pair still waits.
module stable_matching_engine import sme_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [2:0]          person_i,
  input  logic [2:0]          rank_slot_i,
  input  logic [2:0]          choice_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          acceptor_id_o,
  output logic [2:0]          proposer_id_o,
  output logic                last_pair_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [ActiveW-1:0] active_q;
  logic [CntW-1:0]    n;
  cmd_t               cmd;
  status_t            status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
    end else if (psel && penable && pwrite && pready && paddr == AddrActiveCount) begin
      active_q <= pwdata[ActiveW-1:0];
    end
  end

  assign prdata = (paddr == AddrActiveCount) ? CfgDataW'(active_q) : '0;
  assign n      = clamp_count(active_q);

  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  sme_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .n_i           (n),
    .person_i      (person_i),
    .rank_slot_i   (rank_slot_i),
    .choice_i      (choice_i),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .acceptor_id_o (acceptor_id_o),
    .proposer_id_o (proposer_id_o),
    .last_pair_o   (last_pair_o)
  );

endmodule

[rtl/sme_checker.sv]
module sme_checker import sme_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [1:0]          func_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          acceptor_id_o,
  input logic [2:0]          proposer_id_o,
  input logic                last_pair_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [CfgAddrW-1:0] paddr,
  input logic [CfgDataW-1:0] pwdata,
  input logic [CfgDataW-1:0] prdata,
  input logic                pready
);

  // a run request keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FuncRun |=> in_stall_o)
    else $error("run request did not stall input");

  // a pending pair that is not the last means the run is still going
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pair_o |-> in_stall_o)
    else $error("non-final pair pending while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(acceptor_id_o) &&
      $stable(proposer_id_o) && $stable(last_pair_o))
    else $error("stalled pair changed");

  // register readback follows the last write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == AddrActiveCount |=>
      paddr != AddrActiveCount || prdata[ActiveW-1:0] == $past(pwdata[ActiveW-1:0]))
    else $error("active count readback mismatch");

endmodule

bind stable_matching_engine sme_checker u_checker (.*);
